### rtl/core/ipdbd_pkg.sv
// Package for the IR pulse-distance button decoder.
// Holds frame and table constants, the button code table, the match function
// and the queue status type. No dependencies.
package ipdbd_pkg;

  localparam int FRAME_BITS  = 32;
  localparam int NUM_BUTTONS = 11;
  localparam int TABLE_ROWS  = 11;
  localparam int SEARCH_ROWS = (NUM_BUTTONS < TABLE_ROWS) ? NUM_BUTTONS : TABLE_ROWS;

  localparam int TIME_W   = 16;
  localparam int GAP_W    = 16;
  localparam int LEAD_W   = 4;
  localparam int BUTTON_W = 4;
  localparam int RAW_W    = 32;
  localparam int IDX_W    = $clog2(FRAME_BITS + 1);

  localparam logic [GAP_W-1:0]    GAP_RESET  = GAP_W'(25);
  localparam logic [LEAD_W-1:0]   LEAD_RESET = LEAD_W'(3);
  localparam logic [BUTTON_W-1:0] BTN_NONE   = BUTTON_W'(NUM_BUTTONS % 16);
  localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(FRAME_BITS - 1);

  // Register indexes on the configuration port (word address bit 2)
  localparam logic REG_GAP_THRESHOLD = 1'b0;
  localparam logic REG_LEADING_EDGES = 1'b1;

  localparam logic [31:0] CODE_TABLE [TABLE_ROWS] = '{
    32'h00FFA25D,  // power
    32'h00FF629D,  // volume up
    32'h00FFE21D,  // func / stop
    32'h00FF22DD,  // skip left
    32'h00FFE01F,  // arrow down
    32'h00FF906F,  // arrow up
    32'h00FF02FD,  // start / pause
    32'h00FF30CF,  // number 1
    32'h00FF18E7,  // number 2
    32'h00FF7A85,  // number 3
    32'h00FFC23D   // skip right
  };

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fq_status_t;

  // First matching row wins: scan downward so the lowest index is kept.
  function automatic logic [BUTTON_W-1:0] match_button(input frame_t frame);
    logic [BUTTON_W-1:0] result;
    result = BTN_NONE;
    for (int i = SEARCH_ROWS - 1; i >= 0; i--) begin
      if (CODE_TABLE[i][31 -: FRAME_BITS] == frame) begin
        result = BUTTON_W'(i);
      end
    end
    return result;
  endfunction

endpackage

### rtl/core/ipdbd_front.sv
// Front end: skips leading edges, turns edge intervals into bits and
// assembles frames. Depends on ipdbd_pkg.
module ipdbd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         edge_take,
  input  logic [ipdbd_pkg::TIME_W-1:0] edge_time,
  input  logic [ipdbd_pkg::GAP_W-1:0]  gap_threshold,
  input  logic [ipdbd_pkg::LEAD_W-1:0] leading_edges,
  output logic                         frame_push,
  output ipdbd_pkg::frame_t            frame_data
);
  import ipdbd_pkg::*;

  logic [LEAD_W-1:0] skip_r, skip_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  frame_t            bits_r, bits_nxt;

  logic [TIME_W-1:0] interval;
  logic              bit_val;
  frame_t            shifted;

  assign interval = edge_time - last_r;
  assign bit_val  = interval > gap_threshold;
  assign shifted  = {bits_r[FRAME_BITS-2:0], bit_val};

  always_comb begin
    skip_nxt   = skip_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    bits_nxt   = bits_r;
    frame_push = 1'b0;
    if (edge_take) begin
      last_nxt = edge_time;
      if (skip_r != '0) begin
        skip_nxt = skip_r - LEAD_W'(1);
      end else if (idx_r == IDX_LAST) begin
        // frame complete: hand it to the queue and reload the skip count
        frame_push = 1'b1;
        idx_nxt    = '0;
        bits_nxt   = '0;
        skip_nxt   = leading_edges;
      end else begin
        idx_nxt  = idx_r + IDX_W'(1);
        bits_nxt = shifted;
      end
    end
  end

  assign frame_data = shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= LEAD_RESET;
      idx_r  <= '0;
      last_r <= '0;
      bits_r <= '0;
    end else begin
      skip_r <= skip_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
      bits_r <= bits_nxt;
    end
  end

endmodule

### rtl/core/ipdbd_fifo.sv
// Two-entry frame queue between the front and back ends.
// Depends on ipdbd_pkg.
module ipdbd_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  ipdbd_pkg::frame_t       wr_data,
  input  logic                    rd_en,
  output ipdbd_pkg::frame_t       rd_data,
  output ipdbd_pkg::fq_status_t   status
);
  import ipdbd_pkg::*;

  frame_t      mem_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_wr, do_rd;

  assign status.full  = cnt_r == 2'd2;
  assign status.empty = cnt_r == 2'd0;
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? ~wptr_r : wptr_r;
    rptr_nxt = do_rd ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/core/ipdbd_back.sv
// Back end: matches queued frames against the button table and holds the
// result in an output register. Depends on ipdbd_pkg.
module ipdbd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ipdbd_pkg::fq_status_t          q_status,
  input  ipdbd_pkg::frame_t              q_data,
  output logic                           q_pop,
  input  logic                           res_pop,
  output logic                           res_empty,
  output logic [ipdbd_pkg::BUTTON_W-1:0] res_button,
  output logic [ipdbd_pkg::RAW_W-1:0]    res_raw
);
  import ipdbd_pkg::*;

  logic                valid_r, valid_nxt;
  logic [BUTTON_W-1:0] button_r;
  logic [RAW_W-1:0]    raw_r;

  // load when the output slot is free or is drained this cycle
  assign q_pop     = !q_status.empty && (!valid_r || res_pop);
  assign valid_nxt = q_pop || (valid_r && !res_pop);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      button_r <= match_button(q_data);
      raw_r    <= RAW_W'(q_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign res_empty  = !valid_r;
  assign res_button = button_r;
  assign res_raw    = raw_r;

endmodule

### rtl/core/ir_pulse_distance_button_decoder_unit.sv
// Top level of the IR pulse-distance button decoder.
// Instantiates ipdbd_front, ipdbd_fifo and ipdbd_back; uses ipdbd_pkg.
//
// Usage:
//   Input channel: drive in_edge_time with the timer capture of each rising
//   edge and raise push; the edge is taken at a clock edge with full low.
//   Result channel: while empty is low, out_button / out_raw_code hold the
//   oldest decoded frame; raise pop to take it.
//   Configuration: APB-style port, gap_threshold at 0x0, leading_edges at 0x4,
//   always ready. Write only while the decoder is idle.
// Throughput: one edge per cycle while full is low. The front end's subtract and
//   compare and the back end's table compare are each combinational.
// Result path: once the last edge of a frame is accepted, the frame queue write
//   and then the output register load carry its result to the outputs.
// Reset: synchronous, active low. Registers return to gap 25, skip 3; the
//   queue and the output register empty; no partial frame survives.
// Stall: if pop stays low, results pile up in the output register and the
//   two-entry frame queue; full rises only when that queue is full, and edges
//   still flow while the queue has room.
module ir_pulse_distance_button_decoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           push,
  output logic                           full,
  input  logic [ipdbd_pkg::TIME_W-1:0]   in_edge_time,
  // result channel
  output logic                           empty,
  input  logic                           pop,
  output logic [ipdbd_pkg::BUTTON_W-1:0] out_button,
  output logic [ipdbd_pkg::RAW_W-1:0]    out_raw_code,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ipdbd_pkg::*;

  logic [GAP_W-1:0]  gap_r;
  logic [LEAD_W-1:0] lead_r;
  logic              cfg_wr;
  logic              edge_take;
  logic              frame_push;
  frame_t            frame_data;
  frame_t            q_data;
  logic              q_pop;
  fq_status_t        q_stat;

  // ---------------------------------------------------------------------------
  // Configuration registers; word select on address bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= GAP_RESET;
      lead_r <= LEAD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GAP_THRESHOLD) begin
        gap_r <= pwdata[GAP_W-1:0];
      end else begin
        lead_r <= pwdata[LEAD_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GAP_THRESHOLD: prdata = 32'(gap_r);
      REG_LEADING_EDGES: prdata = 32'(lead_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: accept edges whenever the frame queue has room
  // ---------------------------------------------------------------------------
  assign full      = q_stat.full;
  assign edge_take = push && !full;

  ipdbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .edge_take     (edge_take),
    .edge_time     (in_edge_time),
    .gap_threshold (gap_r),
    .leading_edges (lead_r),
    .frame_push    (frame_push),
    .frame_data    (frame_data)
  );

  // Hold finished frames so the front keeps going while the back stalls
  ipdbd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (frame_push),
    .wr_data (frame_data),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .status  (q_stat)
  );

  // Back end: match and present results
  ipdbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_stat),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .res_pop    (pop),
    .res_empty  (empty),
    .res_button (out_button),
    .res_raw    (out_raw_code)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A completed frame must never meet a full queue
  a_no_frame_drop: assert property (@(posedge clk) disable iff (!rst_n)
    frame_push |-> !q_stat.full)
    else $error("frame completed while frame queue full");

  // A waiting frame moves into an empty output slot on the next cycle
  a_back_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_stat.empty && empty) |=> !empty)
    else $error("back end failed to load a queued frame");

  // A presented button code is a table index or the unrecognized code
  a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_button <= BTN_NONE))
    else $error("button code out of range");

  // Queue never drained while empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("frame queue popped while empty");

endmodule

### verif/ir_pulse_distance_button_decoder_checker.sv
// Checker for the IR pulse-distance button decoder: watches the edge, result
// and register ports, predicts every decoded frame and compares it.
// Depends on ipdbd_pkg for widths, frame size and table size.
`timescale 1ns / 1ps

module ir_pulse_distance_button_decoder_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  logic [ipdbd_pkg::TIME_W-1:0]   in_edge_time,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [ipdbd_pkg::BUTTON_W-1:0] out_button,
  input  logic [ipdbd_pkg::RAW_W-1:0]    out_raw_code,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  input  logic [31:0]                    prdata,
  input  logic                           pready,
  output int                             errors,
  output int                             pending,
  output int                             frames_checked,
  output int                             frames_matched
);

  import ipdbd_pkg::*;

  localparam logic [31:0] KEYPAD_CODES [11] = '{
    32'h00FFA25D, 32'h00FF629D, 32'h00FFE21D, 32'h00FF22DD,
    32'h00FFE01F, 32'h00FF906F, 32'h00FF02FD, 32'h00FF30CF,
    32'h00FF18E7, 32'h00FF7A85, 32'h00FFC23D
  };
  localparam int          ROWS_SEARCHED  = (NUM_BUTTONS < 11) ? NUM_BUTTONS : 11;
  localparam logic [31:0] FRAME_MASK     = 32'((64'd1 << FRAME_BITS) - 64'd1);
  localparam logic [3:0]  UNKNOWN_BUTTON = 4'(NUM_BUTTONS);

  typedef struct packed {
    logic [3:0]  button;
    logic [31:0] raw_code;
  } decoded_frame_t;

  decoded_frame_t pending_decodes [$];

  logic [15:0] thr_shadow;
  logic [3:0]  lead_shadow;
  logic [3:0]  skips_left;
  logic [5:0]  bits_taken;
  logic [15:0] prev_stamp;
  logic [31:0] shift_reg;
  int          err_count;
  int          checked_count;
  int          matched_count;

  function automatic logic [3:0] lookup_button(input logic [31:0] frame);
    for (int i = 0; i < ROWS_SEARCHED; i++) begin
      if (((KEYPAD_CODES[i] >> (32 - FRAME_BITS)) & FRAME_MASK) == frame) return 4'(i);
    end
    return UNKNOWN_BUTTON;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Advance the decoder state by one captured edge.
  task automatic decode_edge(input logic [15:0] t);
    logic [15:0]    span;
    decoded_frame_t res;
    if (skips_left != 4'd0) begin
      skips_left--;
      prev_stamp = t;
      return;
    end
    span       = t - prev_stamp;
    prev_stamp = t;
    shift_reg  = ((shift_reg << 1) | 32'(span > thr_shadow)) & FRAME_MASK;
    bits_taken++;
    if (bits_taken >= 6'(FRAME_BITS)) begin
      res.button   = lookup_button(shift_reg);
      res.raw_code = shift_reg;
      pending_decodes.push_back(res);
      bits_taken = '0;
      shift_reg  = '0;
      skips_left = lead_shadow;
    end
  endtask

  always @(posedge clk) begin
    decoded_frame_t want;
    if (!rst_n) begin
      thr_shadow  = GAP_RESET;
      lead_shadow = LEAD_RESET;
      skips_left  = LEAD_RESET;
      bits_taken  = '0;
      prev_stamp  = '0;
      shift_reg   = '0;
      pending_decodes.delete();
    end else begin
      // Check the result side first: an edge taken now cannot be popped now.
      if (pop && !empty) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("result with nothing expected", out_raw_code, 32'h0);
        end else begin
          want = pending_decodes.pop_front();
          checked_count++;
          if (want.button != UNKNOWN_BUTTON) matched_count++;
          if (out_button !== want.button)
            report_mismatch("button", 32'(out_button), 32'(want.button));
          if (out_raw_code !== want.raw_code)
            report_mismatch("raw_code", out_raw_code, want.raw_code);
        end
      end
      if (push && !full) decode_edge(in_edge_time);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_LEADING_EDGES) lead_shadow = pwdata[3:0];
          else thr_shadow = pwdata[15:0];
        end else if (paddr[2] == REG_LEADING_EDGES) begin
          if (prdata[3:0] !== lead_shadow)
            report_mismatch("leading_edges read", 32'(prdata[3:0]), 32'(lead_shadow));
        end else if (prdata[15:0] !== thr_shadow) begin
          report_mismatch("gap_threshold read", 32'(prdata[15:0]), 32'(thr_shadow));
        end
      end
    end
    errors         <= err_count;
    pending        <= pending_decodes.size();
    frames_checked <= checked_count;
    frames_matched <= matched_count;
  end

endmodule

### verif/ir_pulse_distance_button_decoder_unit_tb.sv
// Testbench top for the IR pulse-distance button decoder: clock, reset, edge
// stimulus, result-side stalls, register writes and the verdict.
// Depends on ipdbd_pkg, the decoder top level and the frame checker.
`timescale 1ns / 1ps

module ir_pulse_distance_button_decoder_unit_tb;

  import ipdbd_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int RANDOM_SETTING  = -1;
  localparam int PRESSURE_PHASE  = 3;
  localparam int SPLIT_PHASE     = 4;
  localparam int LONG_HOLD       = 700;
  // Threshold / skip count per phase, extremes first; the last one is drawn.
  localparam int PHASE_GAP  [NUM_PHASES] = '{0, 65535, 3000, 25, 1, 65534, 500, RANDOM_SETTING};
  localparam int PHASE_LEAD [NUM_PHASES] = '{0, 15, 7, 1, 0, 2, 5, RANDOM_SETTING};

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [TIME_W-1:0]   in_edge_time;
  logic                empty;
  logic                pop;
  logic [BUTTON_W-1:0] out_button;
  logic [RAW_W-1:0]    out_raw_code;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int errors;
  int pending_frames;
  int frames_checked;
  int frames_matched;

  // Stimulus bookkeeping
  logic [15:0] stamp;          // time of the last edge sent
  int          cur_gap;
  int          cur_lead;
  int          sent_items;
  int          burst_left;
  bit          steady;         // no sender gaps while set
  int          settings_applied;
  int          hold_requests;  // bumped by the stimulus, served by the receiver

  ir_pulse_distance_button_decoder_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_edge_time (in_edge_time),
    .empty        (empty),
    .pop          (pop),
    .out_button   (out_button),
    .out_raw_code (out_raw_code),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ir_pulse_distance_button_decoder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_edge_time   (in_edge_time),
    .empty          (empty),
    .pop            (pop),
    .out_button     (out_button),
    .out_raw_code   (out_raw_code),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .errors         (errors),
    .pending        (pending_frames),
    .frames_checked (frames_checked),
    .frames_matched (frames_matched)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("[%0t] timeout: decoder stopped making progress", $realtime);
    $display("simulation failed");
    $finish;
  end

  // Receiver: alternate pop runs and stall runs of random length; on request,
  // hold off for a long stretch so the result queue fills and full rises.
  initial begin
    int  run_left;
    int  hold_left;
    int  holds_done;
    bit  pop_on;
    run_left   = 0;
    hold_left  = 0;
    holds_done = 0;
    pop_on     = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
        pop <= 1'b0;
      end else begin
        if (run_left == 0) begin
          pop_on   = ($urandom_range(0, 3) != 0);
          run_left = pop_on ? $urandom_range(1, 40) : $urandom_range(1, 8);
        end
        run_left--;
        pop <= pop_on;
      end
    end
  end

  // Offer one edge and hold it until the decoder takes the transaction.
  // Between bursts, drop push for a random gap.
  task automatic send_edge(input logic [15:0] t);
    if (!steady && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    push         <= 1'b1;
    in_edge_time <= t;
    do @(posedge clk); while (full);
    stamp = t;
    sent_items++;
  endtask

  // Send the edge that carries one data bit. Boundary mode keeps the interval
  // on the extremes: exactly the threshold, one above it, zero or full span.
  task automatic send_bit(input bit b, input bit boundary);
    int thr;
    int iv;
    thr = cur_gap;
    if (b) begin
      if (thr >= 65535) begin
        iv = $urandom_range(0, 65535);          // no interval can be long
      end else if (boundary) begin
        iv = $urandom_range(0, 1) ? thr + 1 : 65535;
      end else if ($urandom_range(0, 3) != 0) begin
        iv = thr + 1 + $urandom_range(0, thr / 2 + 40);
        if (iv > 65535) iv = 65535;
      end else begin
        iv = $urandom_range(thr + 1, 65535);
      end
    end else begin
      if (boundary) iv = $urandom_range(0, 1) ? thr : 0;
      else if ($urandom_range(0, 7) == 0) iv = thr;
      else iv = $urandom_range(0, thr);
    end
    send_edge(stamp + 16'(iv));
  endtask

  // Send the leading edges, then bits hi..lo of code, first bit MSB.
  task automatic send_frame(input logic [31:0] code, input int skips, input int hi,
                            input int lo, input bit boundary);
    for (int k = 0; k < skips; k++) begin
      if (boundary) send_edge((k % 3 == 0) ? 16'hFFFF : (k % 3 == 1) ? 16'h0000 : 16'hFFF0);
      else send_edge(16'($urandom));
    end
    for (int i = hi; i >= lo; i--) send_bit(code[i], boundary);
  endtask

  // Half of the picks are valid button codes; the rest are near misses and noise.
  function automatic logic [31:0] pick_code();
    logic [31:0] row;
    row = CODE_TABLE[$urandom_range(0, TABLE_ROWS - 1)];
    case ($urandom_range(0, 9))
      0, 1:    return row ^ (32'd1 << $urandom_range(0, 31));
      2:       return $urandom;
      3:       return {row[31:8], ~row[7:0]};
      4:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return row;
    endcase
  endfunction

  task automatic cfg_access(input logic wr, input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Return the bus to idle before the next transfer.
    @(posedge clk);
  endtask

  // Drop push and wait until every decoded frame has been taken, then let
  // anything still inside the front end settle.
  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    while (pending_frames != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0] carry_code;
    bit          carry;
    int          target;
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_edge_time <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    stamp            = '0;
    cur_gap          = 25;
    cur_lead         = 3;
    sent_items       = 0;
    burst_left       = 0;
    steady           = 1'b0;
    settings_applied = 1;
    hold_requests    = 0;
    carry            = 1'b0;
    carry_code       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed start at reset settings: wrapping skip edges and boundary
    // intervals for the first bits, then finish the frame at random.
    send_frame(CODE_TABLE[0], 3, 31, 13, 1'b1);
    send_frame(CODE_TABLE[0], 0, 12, 0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      cur_gap  = (PHASE_GAP[p] == RANDOM_SETTING) ? $urandom_range(0, 65535) : PHASE_GAP[p];
      cur_lead = (PHASE_LEAD[p] == RANDOM_SETTING) ? $urandom_range(0, 15) : PHASE_LEAD[p];
      cfg_access(1'b1, REG_GAP_THRESHOLD, {16'($urandom), 16'(cur_gap)});
      cfg_access(1'b1, REG_LEADING_EDGES, {28'($urandom), 4'(cur_lead)});
      cfg_access(1'b0, REG_GAP_THRESHOLD, 32'h0);
      cfg_access(1'b0, REG_LEADING_EDGES, 32'h0);
      settings_applied++;
      // Finish a frame started under the previous settings: the new skip
      // count waits for the frame end, the new threshold applies at once.
      if (carry) begin
        send_frame(carry_code, 0, 15, 0, 1'b0);
        carry = 1'b0;
      end
      if (p == PRESSURE_PHASE) begin
        steady = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target) send_frame(pick_code(), cur_lead, 31, 0, 1'b0);
      steady = 1'b0;
      if (p == SPLIT_PHASE) begin
        carry_code = pick_code();
        send_frame(carry_code, cur_lead, 31, 16, 1'b0);
        carry = 1'b1;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d edges over %0d register settings, %0d frames decoded",
             sent_items, settings_applied, frames_checked);
    $display("%0d frames matched a button, %0d were unrecognized, %0d mismatches",
             frames_matched, frames_checked - frames_matched, errors);
    if (errors == 0 && pending_frames == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ipdbd_pkg.sv
rtl/core/ipdbd_front.sv
rtl/core/ipdbd_fifo.sv
rtl/core/ipdbd_back.sv
rtl/core/ir_pulse_distance_button_decoder_unit.sv
verif/ir_pulse_distance_button_decoder_checker.sv
verif/ir_pulse_distance_button_decoder_unit_tb.sv
